// ----- design/mdhw_pkg.sv -----
// ----------------------------------------------------------------------------
// mdhw_pkg
// Shared types and codes for the multi-device heartbeat watchdog.
// ----------------------------------------------------------------------------
package mdhw_pkg;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned DEV_W     = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned POLL_W    = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER   = 3'd0,
    FN_UNREGISTER = 3'd1,
    FN_HEARTBEAT  = 3'd2,
    FN_TICK       = 3'd3,
    FN_QUERY      = 3'd4
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIMEOUT   = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END
  } state_e;

endpackage

// ----- design/mdhw_cmd_if.sv -----
// ----------------------------------------------------------------------------
// mdhw_cmd_if
// Command channel: valid/ready handshake with one command per beat.
// ----------------------------------------------------------------------------
interface mdhw_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [4:0]  device;
  logic [31:0] timeout_secs;

  modport source (output valid, func, device, timeout_secs, input ready);
  modport sink   (input valid, func, device, timeout_secs, output ready);
endinterface

// ----- design/mdhw_res_if.sv -----
// ----------------------------------------------------------------------------
// mdhw_res_if
// Result channel: valid/ready handshake with one report per beat.
// ----------------------------------------------------------------------------
interface mdhw_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  device_out;
  logic [31:0] elapsed_secs;
  logic        last;

  modport source (output valid, kind, device_out, elapsed_secs, last, input ready);
  modport sink   (input valid, kind, device_out, elapsed_secs, last, output ready);
endinterface

// ----- design/multi_device_heartbeat_watchdog.sv -----
// ----------------------------------------------------------------------------
// multi_device_heartbeat_watchdog
// Slot table of registered devices, one-second time base and periodic scan
// for devices whose heartbeat has gone quiet.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries commands (register, unregister, heartbeat, tick, query),
//   one per beat. res_o carries timeout reports and query answers; last
//   marks the final result a command produces.
//   cfg_we_i/cfg_wdata_i write poll_interval; the user must do so only
//   while the block is idle, as the block itself does not enforce this.
//   Register, unregister, heartbeat and a tick without a scan leave the
//   sequencer idle. A query holds the input in ST_QUERY, where its answer
//   is loaded into the output register once that register is free. A
//   scanning tick walks every slot: ST_SCAN_RD skips an idle slot and
//   reads a live one, which ST_SCAN_EV checks with the one subtract/compare
//   unit; ST_SCAN_END then sends any held-back report.
//   cmd_i.ready is high only while the sequencer is idle.
//   A report is held back one hit so that last can be set on the final one.
//   If res_o stalls, the scan or query waits until the output register is
//   free; nothing is dropped.
//   Reset clears the valid and timed-out marks and the time and arms the
//   countdown; the timeout and last-seen memories need no clearing.
// ----------------------------------------------------------------------------
module multi_device_heartbeat_watchdog
  import mdhw_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [POLL_W-1:0] cfg_wdata_i,
  mdhw_cmd_if.sink          cmd_i,
  mdhw_res_if.source        res_o
);

  localparam int unsigned IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 1);

  // slot state
  logic [MAX_DEVICES-1:0] slot_valid_q, slot_valid_d;
  logic [MAX_DEVICES-1:0] slot_to_q, slot_to_d;     // timed-out marks
  logic [TIME_W-1:0]      tmo_mem [MAX_DEVICES];
  logic [TIME_W-1:0]      seen_mem [MAX_DEVICES];
  logic [TIME_W-1:0]      tmo_rd_q, seen_rd_q;
  logic [IDX_W-1:0]       rd_addr;

  logic [TIME_W-1:0]      now_q, now_d;
  logic [POLL_W-1:0]      poll_q, poll_d;
  logic [POLL_W-1:0]      cdown_q, cdown_d;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [DEV_W-1:0]       qdev_q, qdev_d;
  logic                   qfound_q, qfound_d;

  // held-back report
  logic                   pend_valid_q, pend_valid_d;
  logic [DEV_W-1:0]       pend_dev_q, pend_dev_d;
  logic [TIME_W-1:0]      pend_el_q, pend_el_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [DEV_W-1:0]       out_dev_q, out_dev_d;
  logic [TIME_W-1:0]      out_el_q, out_el_d;
  logic                   out_last_q, out_last_d;
  logic                   out_load;

  logic                   acc;
  logic                   out_free;
  logic                   in_range;
  logic [IDX_W-1:0]       cmd_idx;
  logic [IDX_W-1:0]       scan_idx;
  logic                   scan_done;
  logic                   live;
  logic [TIME_W-1:0]      elapsed;
  logic                   hit;
  logic                   start_scan;
  logic                   mem_tmo_we, mem_seen_we;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign in_range    = (7'(cmd_i.device) < 7'(MAX_DEVICES));
  assign cmd_idx     = IDX_W'(cmd_i.device);
  assign scan_idx    = idx_q[IDX_W-1:0];
  assign scan_done   = (idx_q == CNT_W'(MAX_DEVICES));
  assign live        = slot_valid_q[scan_idx] && !slot_to_q[scan_idx];

  // the shared unit: one subtract, one compare
  assign elapsed     = now_q - seen_rd_q;
  assign hit         = (elapsed >= tmo_rd_q);

  assign start_scan  = acc && (cmd_i.func == FN_TICK) && (cdown_q <= POLL_W'(1));
  assign rd_addr     = (state_q == ST_IDLE) ? cmd_idx : scan_idx;
  assign mem_tmo_we  = acc && (cmd_i.func == FN_REGISTER) && in_range;
  assign mem_seen_we = mem_tmo_we ||
                       (acc && (cmd_i.func == FN_HEARTBEAT) && in_range &&
                        slot_valid_q[cmd_idx]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_scan) begin
          state_d = ST_SCAN_RD;
        end else if (acc && (cmd_i.func == FN_QUERY)) begin
          state_d = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (scan_done) begin
          state_d = ST_SCAN_END;
        end else if (live) begin
          state_d = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (!hit || !pend_valid_q || out_free) state_d = ST_SCAN_RD;
      end
      ST_SCAN_END: begin
        if (!pend_valid_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_to_d    = slot_to_q;
    now_d        = now_q;
    poll_d       = cfg_we_i ? cfg_wdata_i : poll_q;
    cdown_d      = cdown_q;
    idx_d        = idx_q;
    qdev_d       = qdev_q;
    qfound_d     = qfound_q;
    pend_valid_d = pend_valid_q;
    pend_dev_d   = pend_dev_q;
    pend_el_d    = pend_el_q;
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_dev_d    = out_dev_q;
    out_el_d     = out_el_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (cmd_i.func)
            FN_REGISTER: begin
              if (in_range) begin
                slot_valid_d[cmd_idx] = 1'b1;
                slot_to_d[cmd_idx]    = 1'b0;
              end
            end
            FN_UNREGISTER: begin
              if (in_range) slot_valid_d[cmd_idx] = 1'b0;
            end
            FN_HEARTBEAT: begin
              if (in_range && slot_valid_q[cmd_idx]) slot_to_d[cmd_idx] = 1'b0;
            end
            FN_TICK: begin
              now_d = now_q + TIME_W'(1);
              if (cdown_q <= POLL_W'(1)) begin
                cdown_d = (poll_q == '0) ? POLL_W'(1) : poll_q;
                idx_d   = '0;
              end else begin
                cdown_d = cdown_q - POLL_W'(1);
              end
            end
            FN_QUERY: begin
              idx_d    = CNT_W'(cmd_i.device);
              qdev_d   = cmd_i.device;
              qfound_d = in_range && slot_valid_q[cmd_idx];
            end
            default: ;
          endcase
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = qfound_q ? KIND_FOUND : KIND_NOT_FOUND;
          out_dev_d  = qdev_q;
          out_el_d   = qfound_q ? elapsed : '0;
          out_last_d = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        if (!scan_done && !live) idx_d = idx_q + CNT_W'(1);
      end
      ST_SCAN_EV: begin
        if (!hit) begin
          idx_d = idx_q + CNT_W'(1);
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_kind_d = KIND_TIMEOUT;
            out_dev_d  = pend_dev_q;
            out_el_d   = pend_el_q;
            out_last_d = 1'b0;
          end
          slot_to_d[scan_idx] = 1'b1;
          pend_valid_d        = 1'b1;
          pend_dev_d          = DEV_W'(scan_idx);
          pend_el_d           = elapsed;
          idx_d               = idx_q + CNT_W'(1);
        end
      end
      ST_SCAN_END: begin
        if (pend_valid_q && out_free) begin
          out_load     = 1'b1;
          out_kind_d   = KIND_TIMEOUT;
          out_dev_d    = pend_dev_q;
          out_el_d     = pend_el_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      slot_to_q    <= '0;
      now_q        <= '0;
      poll_q       <= POLL_W'(1);
      cdown_q      <= POLL_W'(1);
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      slot_to_q    <= slot_to_d;
      now_q        <= now_d;
      poll_q       <= poll_d;
      cdown_q      <= cdown_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qdev_q     <= qdev_d;
    qfound_q   <= qfound_d;
    pend_dev_q <= pend_dev_d;
    pend_el_q  <= pend_el_d;
    out_kind_q <= out_kind_d;
    out_dev_q  <= out_dev_d;
    out_el_q   <= out_el_d;
    out_last_q <= out_last_d;
  end

  // timeout and last-seen memories, registered read
  always_ff @(posedge clk_i) begin
    if (mem_tmo_we) tmo_mem[cmd_idx] <= cmd_i.timeout_secs;
    if (mem_seen_we) seen_mem[cmd_idx] <= now_q;
    tmo_rd_q  <= tmo_mem[rd_addr];
    seen_rd_q <= seen_mem[rd_addr];
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.device_out   = out_dev_q;
  assign res_o.elapsed_secs = out_el_q;
  assign res_o.last         = out_last_q;

  // checks
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held-back report left behind at end of scan");

  a_cdown_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdown_q != '0)
    else $error("poll countdown reached zero");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_o.ready))
    else $error("output register overwritten while stalled");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_EV) |-> (idx_q < CNT_W'(MAX_DEVICES)))
    else $error("scan index beyond slot table");

endmodule
